// ===== hdl/rbh_pkg.sv =====
// Shared types, constants and helpers for the RSSI beacon homing controller.
// Used by rbh_cfg, rbh_step and the top level; depends on nothing else.

package rbh_pkg;

  // Homing state, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE       = 6'b000001,
    MODE_SEEK_LEFT  = 6'b000010,
    MODE_SEEK_RIGHT = 6'b000100,
    MODE_DRIVE      = 6'b001000,
    MODE_ARRIVED    = 6'b010000,
    MODE_ABORT      = 6'b100000
  } mode_e;

  // Mode codes as they appear on the result bus.
  localparam logic [2:0] MODE_CODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_CODE_SEEK_LEFT  = 3'd1;
  localparam logic [2:0] MODE_CODE_SEEK_RIGHT = 3'd2;
  localparam logic [2:0] MODE_CODE_DRIVE      = 3'd3;
  localparam logic [2:0] MODE_CODE_ARRIVED    = 3'd4;
  localparam logic [2:0] MODE_CODE_ABORT      = 3'd5;

  typedef enum logic [1:0] {
    HEAD_STRAIGHT = 2'd0,
    HEAD_LEFT     = 2'd1,
    HEAD_RIGHT    = 2'd2
  } heading_e;

  // Request commands.
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_CANCEL  = 2'd2;

  // Auto-return reasons.
  localparam logic [1:0] AR_NONE    = 2'd0;
  localparam logic [1:0] AR_SILENCE = 2'd1;
  localparam logic [1:0] AR_WEAK    = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_RSSI    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_RSSI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_RSSI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_SPEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_SPEED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_TMO   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_SILENT = 3'd7;

  // Fixed timing and level constants.
  localparam logic signed [7:0] RSSI_FLOOR         = -8'sd100;
  localparam logic [31:0]       NO_BEACON_ABORT_MS = 32'd10000;
  localparam logic [31:0]       LOST_GRACE_MS      = 32'd500;
  localparam logic [31:0]       SPIN_PHASE_MS      = 32'd1200;
  localparam logic [31:0]       WEAK_HOLD_MS       = 32'd3000;
  localparam logic signed [8:0] DIR_MARGIN         = 9'sd2;

  typedef struct packed {
    logic signed [7:0] lost_rssi;
    logic signed [7:0] weak_rssi;
    logic signed [7:0] close_rssi;
    logic [7:0]        drive_speed;
    logic [7:0]        spin_speed;
    logic [7:0]        near_speed;
    logic [15:0]       beacon_timeout;
    logic [15:0]       stray_silence;
  } cfg_t;

  typedef struct packed {
    logic [31:0]       now;
    logic [1:0]        cmd;
    logic              beacon_valid;
    logic signed [7:0] rssi;
    logic              beam_present;
  } item_t;

  typedef struct packed {
    mode_e             mode;
    logic              request;
    logic signed [7:0] recent_rssi;
    logic [31:0]       beacon_time;
    logic              ever_heard;
    logic signed [7:0] peak_rssi;
    logic signed [7:0] left_peak_rssi;
    heading_e          heading;
    logic [31:0]       phase_start;
    logic [31:0]       weak_start;
    logic              weak_running;
    logic signed [8:0] left_drive;
    logic signed [8:0] right_drive;
  } state_t;

  typedef struct packed {
    logic signed [8:0] motor_left;
    logic signed [8:0] motor_right;
    logic              motor_valid;
    logic              update_flag;
    logic [2:0]        mode;
    logic              requested;
    logic              active;
    logic [1:0]        auto_return;
  } result_t;

  localparam state_t STATE_RESET = '{
    mode:           MODE_IDLE,
    request:        1'b0,
    recent_rssi:    RSSI_FLOOR,
    beacon_time:    32'd0,
    ever_heard:     1'b0,
    peak_rssi:      RSSI_FLOOR,
    left_peak_rssi: RSSI_FLOOR,
    heading:        HEAD_STRAIGHT,
    phase_start:    32'd0,
    weak_start:     32'd0,
    weak_running:   1'b0,
    left_drive:     9'sd0,
    right_drive:    9'sd0
  };

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    unique case (m)
      MODE_IDLE:       code = MODE_CODE_IDLE;
      MODE_SEEK_LEFT:  code = MODE_CODE_SEEK_LEFT;
      MODE_SEEK_RIGHT: code = MODE_CODE_SEEK_RIGHT;
      MODE_DRIVE:      code = MODE_CODE_DRIVE;
      MODE_ARRIVED:    code = MODE_CODE_ARRIVED;
      MODE_ABORT:      code = MODE_CODE_ABORT;
      default:         code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/rssi_beacon_homing_controller.sv =====
// RSSI beacon homing controller: input stage, controller state, result register.
// Throughput: one event per clock while the result side is not stalled; the
// single-pass step logic (three 32-bit elapsed-time subtractors feeding
// compares) sets the clock, not the rate.
// Reset (rst_ni low, asynchronous) empties both stages, restores the config
// defaults and puts the controller idle with no beacon heard.

module rssi_beacon_homing_controller (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Event stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: now_ms[31:0], request_cmd[33:32], beacon_valid[34], rssi[42:35],
  // beam_present[43], zero fill[47:44].
  input  logic [47:0] s_axis_tdata,

  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: motor_left[8:0], motor_right[17:9], motor_valid[18], update_flag[19],
  // mode[22:20], requested_out[23], active_out[24], auto_return[26:25],
  // zero fill[31:27].
  output logic [31:0] m_axis_tdata,

  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [rbh_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [15:0]                   cfg_data_i
);

  rbh_pkg::cfg_t    cfg;
  rbh_pkg::item_t   in_item_q;
  logic             in_valid_q;
  rbh_pkg::state_t  state_q;
  rbh_pkg::state_t  state_d;
  rbh_pkg::result_t result_d;
  rbh_pkg::result_t out_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_take;

  rbh_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register moves whenever it is empty or being drained, so the
  // input register can refill in the same cycle it hands its event on.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.now          <= s_axis_tdata[31:0];
      in_item_q.cmd          <= s_axis_tdata[33:32];
      in_item_q.beacon_valid <= s_axis_tdata[34];
      in_item_q.rssi         <= s_axis_tdata[42:35];
      in_item_q.beam_present <= s_axis_tdata[43];
    end
  end

  // The four sub-steps of one event run in one pass, each on the state the last left.
  rbh_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Controller state commits only when its event moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbh_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.auto_return, out_q.active, out_q.requested,
                          out_q.mode, out_q.update_flag, out_q.motor_valid,
                          out_q.motor_right, out_q.motor_left};

`ifndef NO_ASSERTIONS
  // A held event must not be lost or altered while the result side stalls.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("input event dropped or changed during stall");

  // Auto-return always leaves a pending request behind.
  a_ar_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.auto_return != rbh_pkg::AR_NONE) |-> out_q.requested)
    else $error("auto-return without request");

  // Arrived is sticky for the update step, which then reports success.
  a_arrived_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.mode == rbh_pkg::MODE_CODE_ARRIVED) |-> out_q.update_flag)
    else $error("arrived without update flag");

  // In arrived or abort the motors are stopped.
  a_stop_motors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((out_q.mode == rbh_pkg::MODE_CODE_ARRIVED) ||
                    (out_q.mode == rbh_pkg::MODE_CODE_ABORT))
    |-> (out_q.motor_left == 9'sd0) && (out_q.motor_right == 9'sd0))
    else $error("motors running in a terminal mode");
`endif

endmodule

// ===== hdl/rbh_cfg.sv =====
// Configuration register file of the homing controller.
// Depends on rbh_pkg for the register indexes and the cfg_t layout.

module rbh_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbh_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [15:0]                       cfg_data_i,
  output rbh_pkg::cfg_t                     cfg_o
);

  rbh_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lost_rssi      <= -8'sd75;
      cfg_q.weak_rssi      <= -8'sd85;
      cfg_q.close_rssi     <= -8'sd55;
      cfg_q.drive_speed    <= 8'd120;
      cfg_q.spin_speed     <= 8'd80;
      cfg_q.near_speed     <= 8'd60;
      cfg_q.beacon_timeout <= 16'd3000;
      cfg_q.stray_silence  <= 16'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rbh_pkg::REG_LOST_RSSI:    cfg_q.lost_rssi      <= cfg_data_i[7:0];
        rbh_pkg::REG_WEAK_RSSI:    cfg_q.weak_rssi      <= cfg_data_i[7:0];
        rbh_pkg::REG_CLOSE_RSSI:   cfg_q.close_rssi     <= cfg_data_i[7:0];
        rbh_pkg::REG_DRIVE_SPEED:  cfg_q.drive_speed    <= cfg_data_i[7:0];
        rbh_pkg::REG_SPIN_SPEED:   cfg_q.spin_speed     <= cfg_data_i[7:0];
        rbh_pkg::REG_NEAR_SPEED:   cfg_q.near_speed     <= cfg_data_i[7:0];
        rbh_pkg::REG_BEACON_TMO:   cfg_q.beacon_timeout <= cfg_data_i;
        rbh_pkg::REG_STRAY_SILENT: cfg_q.stray_silence  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/rbh_step.sv =====
// Combinational next-state and result logic for one event of the homing controller.
// Depends on rbh_pkg for the state, item, configuration and result types.

module rbh_step (
  input  rbh_pkg::item_t  item_i,
  input  rbh_pkg::state_t state_i,
  input  rbh_pkg::cfg_t   cfg_i,
  output rbh_pkg::state_t state_o,
  output rbh_pkg::result_t result_o
);

  rbh_pkg::state_t   nx;
  logic              upd;
  logic [1:0]        ar;
  logic              phase_now;
  logic              wstart_now;
  logic [31:0]       d_phase_old;
  logic [31:0]       d_beacon_old;
  logic [31:0]       d_weak_old;
  logic [31:0]       d_phase;
  logic [31:0]       d_beacon;
  logic [31:0]       d_weak;
  logic              abort_hit;
  logic              silent_hit;
  logic              weak_hit;
  logic [8:0]        spin9;
  logic [8:0]        speed9;
  logic              nx_active;

  // Elapsed times against the stored timestamps, all modulo 2^32.
  assign d_phase_old  = item_i.now - state_i.phase_start;
  assign d_beacon_old = item_i.now - state_i.beacon_time;
  assign d_weak_old   = item_i.now - state_i.weak_start;

  // A request from idle restarts the phase timer, and a first weak beacon starts
  // the weak timer; both depend only on the stored state, the event and the config.
  assign phase_now  = (item_i.cmd == rbh_pkg::CMD_REQUEST) &&
                      (state_i.mode == rbh_pkg::MODE_IDLE);
  assign wstart_now = item_i.beacon_valid && (item_i.rssi < cfg_i.weak_rssi) &&
                      !state_i.weak_running;

  // A timestamp captured by this same event has zero elapsed time.
  assign d_phase  = phase_now ? 32'd0 : d_phase_old;
  assign d_beacon = item_i.beacon_valid ? 32'd0 : d_beacon_old;
  assign d_weak   = wstart_now ? 32'd0 : d_weak_old;

  assign spin9 = {1'b0, cfg_i.spin_speed};

  always_comb begin
    nx         = state_i;
    upd        = 1'b0;
    ar         = rbh_pkg::AR_NONE;
    abort_hit  = 1'b0;
    silent_hit = 1'b0;
    weak_hit   = 1'b0;
    speed9     = 9'd0;
    nx_active  = 1'b0;

    // Request or cancel.
    case (item_i.cmd)
      rbh_pkg::CMD_REQUEST: begin
        nx.request = 1'b1;
        if (nx.mode == rbh_pkg::MODE_IDLE) begin
          nx.mode        = rbh_pkg::MODE_SEEK_LEFT;
          nx.phase_start = item_i.now;
          nx.peak_rssi   = nx.recent_rssi;
        end
      end
      rbh_pkg::CMD_CANCEL: begin
        nx.request = 1'b0;
        nx.mode    = rbh_pkg::MODE_IDLE;
      end
      default: begin
      end
    endcase

    // Beacon report.
    if (item_i.beacon_valid) begin
      nx.recent_rssi = item_i.rssi;
      nx.beacon_time = item_i.now;
      nx.ever_heard  = 1'b1;
      if (item_i.rssi < cfg_i.weak_rssi) begin
        if (!nx.weak_running) begin
          nx.weak_running = 1'b1;
          nx.weak_start   = item_i.now;
        end
      end else begin
        nx.weak_running = 1'b0;
      end
    end

    // Homing update.
    if (nx.request || (nx.mode != rbh_pkg::MODE_IDLE)) begin
      nx.left_drive  = 9'sd0;
      nx.right_drive = 9'sd0;
      abort_hit = nx.ever_heard ? (d_beacon > {16'd0, cfg_i.beacon_timeout})
                                : (d_phase > rbh_pkg::NO_BEACON_ABORT_MS);
      if ((nx.mode == rbh_pkg::MODE_ARRIVED) || (nx.mode == rbh_pkg::MODE_ABORT)) begin
        upd = (nx.mode == rbh_pkg::MODE_ARRIVED);
      end else if (abort_hit) begin
        nx.mode    = rbh_pkg::MODE_ABORT;
        nx.request = 1'b0;
        upd        = 1'b1;
      end else if (item_i.beam_present) begin
        nx.mode    = rbh_pkg::MODE_ARRIVED;
        nx.request = 1'b0;
        upd        = 1'b1;
      end else if ((nx.mode == rbh_pkg::MODE_SEEK_LEFT) ||
                   (nx.mode == rbh_pkg::MODE_SEEK_RIGHT)) begin
        if (nx.recent_rssi > nx.peak_rssi) begin
          nx.peak_rssi = nx.recent_rssi;
        end
        if (d_phase >= rbh_pkg::SPIN_PHASE_MS) begin
          if (nx.mode == rbh_pkg::MODE_SEEK_LEFT) begin
            nx.left_peak_rssi = nx.peak_rssi;
            nx.mode           = rbh_pkg::MODE_SEEK_RIGHT;
            nx.phase_start    = item_i.now;
            nx.peak_rssi      = rbh_pkg::RSSI_FLOOR;
          end else begin
            if (9'(nx.peak_rssi) > 9'(nx.left_peak_rssi) + rbh_pkg::DIR_MARGIN) begin
              nx.heading = rbh_pkg::HEAD_RIGHT;
            end else if (9'(nx.left_peak_rssi) > 9'(nx.peak_rssi) + rbh_pkg::DIR_MARGIN) begin
              nx.heading = rbh_pkg::HEAD_LEFT;
            end else begin
              nx.heading = rbh_pkg::HEAD_STRAIGHT;
            end
            nx.mode        = rbh_pkg::MODE_DRIVE;
            nx.phase_start = item_i.now;
          end
        end
        if (nx.mode == rbh_pkg::MODE_SEEK_LEFT) begin
          nx.left_drive  = $signed(9'd0 - spin9);
          nx.right_drive = $signed(spin9);
        end else begin
          nx.left_drive  = $signed(spin9);
          nx.right_drive = $signed(9'd0 - spin9);
        end
        upd = 1'b1;
      end else if (nx.mode == rbh_pkg::MODE_DRIVE) begin
        speed9 = (nx.recent_rssi >= cfg_i.close_rssi) ? {1'b0, cfg_i.near_speed}
                                                     : {1'b0, cfg_i.drive_speed};
        if ((nx.recent_rssi < cfg_i.lost_rssi) && (d_phase > rbh_pkg::LOST_GRACE_MS)) begin
          nx.mode        = rbh_pkg::MODE_SEEK_LEFT;
          nx.phase_start = item_i.now;
          nx.peak_rssi   = rbh_pkg::RSSI_FLOOR;
        end else begin
          case (nx.heading)
            rbh_pkg::HEAD_LEFT: begin
              nx.left_drive  = $signed(9'd0 - speed9);
              nx.right_drive = $signed(speed9);
            end
            rbh_pkg::HEAD_RIGHT: begin
              nx.left_drive  = $signed(speed9);
              nx.right_drive = $signed(9'd0 - speed9);
            end
            default: begin
              nx.left_drive  = $signed(speed9);
              nx.right_drive = $signed(speed9);
            end
          endcase
        end
        upd = 1'b1;
      end
    end

    // Auto-return check.
    nx_active = (nx.mode == rbh_pkg::MODE_SEEK_LEFT) ||
                (nx.mode == rbh_pkg::MODE_SEEK_RIGHT) ||
                (nx.mode == rbh_pkg::MODE_DRIVE);
    if (!nx.request && !nx_active && nx.ever_heard) begin
      silent_hit = d_beacon > {16'd0, cfg_i.stray_silence};
      weak_hit   = nx.weak_running && (d_weak > rbh_pkg::WEAK_HOLD_MS);
      if (silent_hit || weak_hit) begin
        nx.request = 1'b1;
        if (nx.mode == rbh_pkg::MODE_IDLE) begin
          nx.mode        = rbh_pkg::MODE_SEEK_LEFT;
          nx.phase_start = item_i.now;
          nx.peak_rssi   = nx.recent_rssi;
        end
        if (silent_hit) begin
          ar = rbh_pkg::AR_SILENCE;
        end else begin
          nx.weak_running = 1'b0;
          ar = rbh_pkg::AR_WEAK;
        end
      end
    end
  end

  assign state_o = nx;

  assign result_o.motor_left  = nx.left_drive;
  assign result_o.motor_right = nx.right_drive;
  assign result_o.motor_valid = (nx.mode != rbh_pkg::MODE_IDLE) &&
                                (nx.mode != rbh_pkg::MODE_ABORT);
  assign result_o.update_flag = upd;
  assign result_o.mode        = rbh_pkg::mode_code(nx.mode);
  assign result_o.requested   = nx.request;
  assign result_o.active      = (nx.mode == rbh_pkg::MODE_SEEK_LEFT) ||
                                (nx.mode == rbh_pkg::MODE_SEEK_RIGHT) ||
                                (nx.mode == rbh_pkg::MODE_DRIVE);
  assign result_o.auto_return = ar;

endmodule
